/* rtl/gcode_tool_number_remapper_defines.svh */
// Assertion macros for the tool number remapper.
`ifndef GCODE_TOOL_NUMBER_REMAPPER_DEFINES_SVH
`define GCODE_TOOL_NUMBER_REMAPPER_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define GTR_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define GTR_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define GTR_ASSERT_IMP(label, clk, rst_n, pre, post)
`define GTR_ASSERT_NXT(label, clk, rst_n, pre, post)

`endif

`endif

/* rtl/gtr_pkg.sv */
package gtr_pkg;

  localparam int unsigned MAX_DIGITS_DEF  = 8;
  localparam int unsigned MAP_ENTRIES_DEF = 32;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned ENTRIES_PER_REG = 8;

  // Saturation point of the source tool value
  localparam logic [5:0] SRC_SAT = 6'd32;

  localparam logic [7:0] CHR_UPPER_T = 8'h54;
  localparam logic [7:0] CHR_LOWER_T = 8'h74;
  localparam logic [7:0] CHR_SEMI    = 8'h3b;
  localparam logic [7:0] CHR_NL      = 8'h0a;
  localparam logic [7:0] CHR_TAB     = 8'h09;
  localparam logic [7:0] CHR_VT      = 8'h0b;
  localparam logic [7:0] CHR_FF      = 8'h0c;
  localparam logic [7:0] CHR_CR      = 8'h0d;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  typedef struct packed {
    logic load;  // input item accepted
    logic step;  // result item accepted
  } dp_cmd_t;

  typedef struct packed {
    logic has_out;  // the item offered now causes at least one result
    logic last;     // the current result is the last of its item
  } dp_sts_t;

  // Target tool in decimal, most significant digit first
  typedef struct packed {
    logic [1:0] len;
    logic [3:0] d0;
    logic [3:0] d1;
    logic [3:0] d2;
  } dec_t;

  function automatic dec_t dec3(logic [6:0] t);
    dec_t        r;
    logic        h;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tn;
    logic [6:0]  ones;
    h    = (t >= 7'd100);
    rem  = h ? (t - 7'd100) : t;
    // rem / 10 via reciprocal, exact for rem < 100
    prod = {8'b0, rem} * 15'd205;
    tn   = prod[14:11];
    ones = rem - ({3'b0, tn} * 7'd10);
    r    = '0;
    if (h) begin
      r.len = 2'd3;
      r.d0  = 4'd1;
      r.d1  = tn;
      r.d2  = ones[3:0];
    end else if (tn != 4'd0) begin
      r.len = 2'd2;
      r.d0  = tn;
      r.d1  = ones[3:0];
    end else begin
      r.len = 2'd1;
      r.d0  = ones[3:0];
    end
    return r;
  endfunction

endpackage

/* rtl/gtr_if.sv */
interface gtr_in_if;
  import gtr_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;
  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface gtr_out_if;
  import gtr_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

interface gtr_cfg_if;
  import gtr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;
  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

/* rtl/gtr_ctrl.sv */
module gtr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  gtr_pkg::dp_sts_t  sts_i,
  output gtr_pkg::dp_cmd_t  cmd_o
);
  import gtr_pkg::*;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = in_valid_i & in_ready_q;
  assign cmd_o.step  = out_valid_q & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_q && sts_i.has_out) begin
            state_q     <= S_EMIT;
            in_ready_q  <= 1'b0;
            out_valid_q <= 1'b1;
          end
        end
        S_EMIT: begin
          if (out_ready_i && sts_i.last) begin
            state_q     <= S_IDLE;
            in_ready_q  <= 1'b1;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* rtl/gtr_dp.sv */
module gtr_dp #(
  parameter int unsigned MAX_DIGITS  = gtr_pkg::MAX_DIGITS_DEF,
  parameter int unsigned MAP_ENTRIES = gtr_pkg::MAP_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gtr_pkg::dp_cmd_t               cmd_i,
  output gtr_pkg::dp_sts_t               sts_o,
  input  logic [7:0]                     in_byte_i,
  input  logic                           stream_end_i,
  output logic [7:0]                     out_byte_o,
  output logic                           run_last_o,
  input  logic                           cfg_we_i,
  input  logic [gtr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gtr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gtr_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned HIDX_W = $clog2(MAX_DIGITS);
  localparam int unsigned OIDX_W = $clog2(MAX_DIGITS + 2);
  localparam int unsigned MIDX_W = $clog2(MAP_ENTRIES);

  // parse state
  logic             in_comment_q, in_comment_d;
  logic             at_start_q, at_start_d;
  logic             after_t_q, after_t_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [5:0]       src_q, src_d;

  logic [3:0]       held_q [MAX_DIGITS];
  logic [7:0]       map_q  [MAP_ENTRIES];

  // plan of the item being emitted
  logic [7:0]        c_q;
  logic              raw_q;
  logic [CNT_W-1:0]  fl_len_q;
  dec_t              dec_q;
  logic [OIDX_W-1:0] total_q;
  logic [OIDX_W-1:0] idx_q;

  logic       is_dig, is_ws, is_tool;
  logic [3:0] dval;
  logic       holding;
  logic       hold_en, plain, emit_c, fl_cur, force_raw;
  logic       fl_end, fl_en;
  logic [CNT_W-1:0] fl_cnt, fl_len;
  logic [5:0] fl_src;
  logic [8:0] acc;
  logic [7:0] entry;
  logic       mapped;
  dec_t       dec;
  logic [OIDX_W-1:0] total_d;

  assign is_dig  = (in_byte_i >= CHR_ZERO) && (in_byte_i <= CHR_NINE);
  assign is_ws   = (in_byte_i == CHR_SPACE) || (in_byte_i == CHR_TAB) ||
                   (in_byte_i == CHR_NL) || (in_byte_i == CHR_VT) ||
                   (in_byte_i == CHR_FF) || (in_byte_i == CHR_CR);
  assign is_tool = (in_byte_i == CHR_UPPER_T) || (in_byte_i == CHR_LOWER_T);
  assign dval    = in_byte_i[3:0];
  assign holding = (count_q != '0);
  assign acc     = ({3'b0, src_q} * 9'd10) + {5'b0, dval};

  always_comb begin
    in_comment_d = in_comment_q;
    at_start_d   = at_start_q;
    after_t_d    = after_t_q;
    count_d      = count_q;
    src_d        = src_q;
    hold_en      = 1'b0;
    plain        = 1'b0;
    emit_c       = 1'b0;
    fl_cur       = 1'b0;
    force_raw    = 1'b0;

    if (holding) begin
      if (is_dig) begin
        if (count_q < CNT_W'(MAX_DIGITS)) begin
          hold_en = 1'b1;
        end else begin
          // overlong token: held digits and this one go out unchanged
          fl_cur     = 1'b1;
          force_raw  = 1'b1;
          emit_c     = 1'b1;
          count_d    = '0;
          src_d      = '0;
          at_start_d = 1'b0;
        end
      end else begin
        fl_cur  = 1'b1;
        plain   = 1'b1;
        count_d = '0;
        src_d   = '0;
      end
    end else if (after_t_q) begin
      after_t_d = 1'b0;
      if (is_dig) begin
        hold_en = 1'b1;
      end else begin
        plain = 1'b1;
      end
    end else begin
      plain = 1'b1;
    end

    if (hold_en) begin
      count_d    = count_q + 1'b1;
      src_d      = (acc > {3'b0, SRC_SAT}) ? SRC_SAT : acc[5:0];
      at_start_d = 1'b0;
    end

    if (plain) begin
      emit_c = 1'b1;
      if (in_comment_q) begin
        if (in_byte_i == CHR_NL) begin
          in_comment_d = 1'b0;
        end
      end else if (in_byte_i == CHR_SEMI) begin
        in_comment_d = 1'b1;
      end else if (at_start_q && is_tool) begin
        after_t_d = 1'b1;
      end
      at_start_d = is_ws;
    end

    // stream end flushes a token still held, then restarts the parse
    fl_end = stream_end_i && (count_d != '0);
    fl_en  = fl_cur | fl_end;
    fl_cnt = fl_cur ? count_q : count_d;
    fl_src = fl_cur ? src_q : src_d;

    if (stream_end_i) begin
      in_comment_d = 1'b0;
      at_start_d   = 1'b1;
      after_t_d    = 1'b0;
      count_d      = '0;
      src_d        = '0;
    end
  end

  assign entry  = map_q[fl_src[MIDX_W-1:0]];
  assign mapped = (fl_src < 6'(MAP_ENTRIES)) && entry[7] && !force_raw;
  assign dec    = dec3(entry[6:0]);
  assign fl_len = !fl_en ? '0 : (mapped ? CNT_W'(dec.len) : fl_cnt);
  assign total_d = OIDX_W'(fl_len) + OIDX_W'(emit_c);

  assign sts_o.has_out = fl_en | emit_c;
  assign sts_o.last    = (idx_q == (total_q - OIDX_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_comment_q <= 1'b0;
      at_start_q   <= 1'b1;
      after_t_q    <= 1'b0;
      count_q      <= '0;
      src_q        <= '0;
      idx_q        <= '0;
    end else begin
      if (cmd_i.load) begin
        in_comment_q <= in_comment_d;
        at_start_q   <= at_start_d;
        after_t_q    <= after_t_d;
        count_q      <= count_d;
        src_q        <= src_d;
        idx_q        <= '0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_q      <= in_byte_i;
      raw_q    <= !mapped;
      fl_len_q <= fl_len;
      dec_q    <= dec;
      total_q  <= total_d;
      if (hold_en) begin
        held_q[count_q[HIDX_W-1:0]] <= dval;
      end
    end
  end

  for (genvar e = 0; e < MAP_ENTRIES; e++) begin : g_map
    localparam int unsigned RegSel = e / ENTRIES_PER_REG;
    localparam int unsigned ByteLo = (e % ENTRIES_PER_REG) * 8;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        map_q[e] <= '0;
      end else if (cfg_we_i && (cfg_idx_i == CFG_IDX_W'(RegSel))) begin
        map_q[e] <= cfg_data_i[ByteLo +: 8];
      end
    end
  end

  // result byte: flushed digits first, then the input byte itself
  logic       is_digit_out;
  logic [3:0] dg, md;

  always_comb begin
    case (idx_q[1:0])
      2'd0:    md = dec_q.d0;
      2'd1:    md = dec_q.d1;
      default: md = dec_q.d2;
    endcase
    is_digit_out = (idx_q < OIDX_W'(fl_len_q));
    dg           = raw_q ? held_q[idx_q[HIDX_W-1:0]] : md;
    out_byte_o   = is_digit_out ? {ASCII_DIGIT_HI, dg} : c_q;
  end

  assign run_last_o = sts_o.last;

endmodule

/* rtl/gcode_tool_number_remapper.sv */
// Input bytes are accepted when no results are pending.
// Each byte yields 0 to MAX_DIGITS+1 result bytes, leaving one per cycle while the
// receiver is ready, the first in the cycle after acceptance.
// A held digit yields no result unless the stream ends on it.
// Reset (rst_ni, async, low) clears the parse state to line start and the table to 0.
`include "gcode_tool_number_remapper_defines.svh"

module gcode_tool_number_remapper #(
  parameter int unsigned MAX_DIGITS  = gtr_pkg::MAX_DIGITS_DEF,
  parameter int unsigned MAP_ENTRIES = gtr_pkg::MAP_ENTRIES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gtr_in_if.sink    in_i,
  gtr_out_if.source out_o,
  gtr_cfg_if.sink   cfg_i
);
  import gtr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_i.ready = 1'b1;

  gtr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gtr_dp #(
    .MAX_DIGITS  (MAX_DIGITS),
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_byte_i    (in_i.in_byte),
    .stream_end_i (in_i.stream_end),
    .out_byte_o   (out_o.out_byte),
    .run_last_o   (out_o.run_last),
    .cfg_we_i     (cfg_i.valid),
    .cfg_idx_i    (cfg_i.reg_index),
    .cfg_data_i   (cfg_i.reg_data)
  );

  `GTR_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_o.valid, !in_i.ready)
  `GTR_ASSERT_NXT(a_last_frees, clk_i, rst_ni, out_o.valid && out_o.ready && out_o.run_last, in_i.ready)
  `GTR_ASSERT_NXT(a_run_goes_on, clk_i, rst_ni, out_o.valid && out_o.ready && !out_o.run_last, out_o.valid)

endmodule

/* dv/tool_remap_checker.sv */
`timescale 1ns / 1ps

module tool_remap_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [7:0]                     in_byte_i,
  input  logic                           stream_end_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [7:0]                     out_byte_i,
  input  logic                           run_last_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [gtr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gtr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    err_count_o,
  output int unsigned                    pending_o
);
  import gtr_pkg::*;

  localparam int unsigned NUM_MAP_REGS = 4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } text_item_t;

  text_item_t expected_text_q[$];

  logic [CFG_DATA_W-1:0] map_regs [NUM_MAP_REGS];
  logic                  in_comment;
  logic                  at_line_pos;
  logic                  after_letter;
  int unsigned           held_cnt;
  logic [3:0]            held_digits [MAX_DIGITS_DEF];
  int unsigned           src_tool;
  int unsigned           errs;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHR_ZERO) && (c <= CHR_NINE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CHR_SPACE, CHR_TAB, CHR_NL, CHR_VT, CHR_FF, CHR_CR};
  endfunction

  function automatic void emit(input logic [7:0] c);
    text_item_t t;
    t.out_byte = c;
    t.run_last = 1'b0;
    expected_text_q = {expected_text_q, t};
  endfunction

  function automatic void emit_held_raw();
    for (int unsigned i = 0; i < held_cnt && i < MAX_DIGITS_DEF; i++) begin
      emit(CHR_ZERO + {4'd0, held_digits[i]});
    end
  endfunction

  function automatic void hold_digit(input logic [3:0] d);
    int unsigned v;
    if (held_cnt < MAX_DIGITS_DEF) held_digits[held_cnt] = d;
    held_cnt++;
    v = src_tool * 10 + int'(d);
    src_tool = (v > int'(SRC_SAT)) ? int'(SRC_SAT) : v;
  endfunction

  function automatic void flush_token();
    logic [7:0]  entry;
    int unsigned tgt;
    entry = '0;
    if (src_tool < int'(SRC_SAT) && src_tool < MAP_ENTRIES_DEF) begin
      entry = map_regs[src_tool / 8][(src_tool % 8) * 8 +: 8];
    end
    if (entry[7]) begin
      tgt = int'(entry[6:0]);
      if (tgt >= 100) emit(CHR_ZERO + 8'(tgt / 100));
      if (tgt >= 10) emit(CHR_ZERO + 8'((tgt / 10) % 10));
      emit(CHR_ZERO + 8'(tgt % 10));
    end else begin
      emit_held_raw();
    end
    held_cnt = 0;
    src_tool = 0;
  endfunction

  function automatic void plain_byte(input logic [7:0] c);
    if (in_comment) begin
      if (c == CHR_NL) in_comment = 1'b0;
    end else if (c == CHR_SEMI) begin
      in_comment = 1'b1;
    end else if (at_line_pos && (c == CHR_UPPER_T || c == CHR_LOWER_T)) begin
      after_letter = 1'b1;
    end
    emit(c);
    at_line_pos = is_space(c);
  endfunction

  function automatic void clear_parse();
    in_comment   = 1'b0;
    at_line_pos  = 1'b1;
    after_letter = 1'b0;
    held_cnt     = 0;
    src_tool     = 0;
  endfunction

  function automatic void predict_remap(input logic [7:0] c, input logic last);
    int unsigned first;
    first = expected_text_q.size();
    if (held_cnt > 0) begin
      if (is_digit(c)) begin
        if (held_cnt < MAX_DIGITS_DEF) begin
          hold_digit(c[3:0]);
        end else begin
          // overlong token: everything so far goes out as is
          emit_held_raw();
          emit(c);
          held_cnt    = 0;
          src_tool    = 0;
          at_line_pos = 1'b0;
        end
      end else begin
        flush_token();
        plain_byte(c);
      end
    end else if (after_letter) begin
      after_letter = 1'b0;
      if (is_digit(c)) begin
        held_cnt = 0;
        src_tool = 0;
        hold_digit(c[3:0]);
        at_line_pos = 1'b0;
      end else begin
        plain_byte(c);
      end
    end else begin
      plain_byte(c);
    end
    if (last) begin
      if (held_cnt > 0) flush_token();
      clear_parse();
    end
    if (expected_text_q.size() > first) begin
      expected_text_q[expected_text_q.size() - 1].run_last = 1'b1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    text_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MAP_REGS; i++) map_regs[i] = '0;
      clear_parse();
      expected_text_q.delete();
      errs = 0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < NUM_MAP_REGS) begin
        map_regs[cfg_index_i] = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_text_q.size() == 0) begin
          $error("unexpected item: out_byte %h run_last %b", out_byte_i, run_last_i);
          errs++;
        end else begin
          want = expected_text_q.pop_front();
          if (out_byte_i !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_byte_i);
            errs++;
          end
          if (run_last_i !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, run_last_i);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_remap(in_byte_i, stream_end_i);
      err_count_o <= errs;
      pending_o   <= expected_text_q.size();
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import gtr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned PHASE_ITEMS    = 50;

  logic clk_i;
  logic rst_ni;

  gtr_in_if  in_if ();
  gtr_out_if out_if ();
  gtr_cfg_if cfg_if ();

  int unsigned err_count;
  int unsigned pending;
  int unsigned burst_left;
  int unsigned quiet_cycles;
  logic        hold_req;
  logic        hold_done;
  int unsigned hold_left;
  int unsigned stall_mode;
  int unsigned mode_left;
  logic [7:0]  text_q[$];

  gcode_tool_number_remapper DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  tool_remap_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_byte_i    (in_if.in_byte),
    .stream_end_i (in_if.stream_end),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_byte_i   (out_if.out_byte),
    .run_last_i   (out_if.run_last),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_ready_i  (cfg_if.ready),
    .cfg_index_i  (cfg_if.reg_index),
    .cfg_data_i   (cfg_if.reg_data),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // receiver: stall pattern is redrawn at random, plus one long hold
  initial out_if.ready = 1'b0;
  initial begin
    hold_left = 0;
    hold_done = 1'b0;
    mode_left = 0;
    stall_mode = 0;
  end
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 80);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_if.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= $urandom_range(0, 1) == 0;
        2: out_if.ready <= $urandom_range(0, 3) == 0;
        default: out_if.ready <= $urandom_range(0, 3) != 0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= b;
    in_if.stream_end <= last;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic write_map(input int unsigned idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx[CFG_IDX_W-1:0];
    cfg_if.reg_data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic load_table(input logic [CFG_DATA_W-1:0] r0, input logic [CFG_DATA_W-1:0] r1,
                            input logic [CFG_DATA_W-1:0] r2, input logic [CFG_DATA_W-1:0] r3);
    write_map(0, r0);
    write_map(1, r1);
    write_map(2, r2);
    write_map(3, r3);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic void add_char(input logic [7:0] c);
    text_q = {text_q, c};
  endfunction

  // send text_q; the final byte always ends the stream
  task automatic send_text();
    int unsigned n;
    n = text_q.size();
    for (int unsigned i = 0; i < n; i++) begin
      send_byte(text_q[i], (i == n - 1) || ($urandom_range(0, 79) == 0));
    end
    text_q.delete();
  endtask

  function automatic logic [7:0] any_space();
    case ($urandom_range(0, 5))
      0: return CHR_SPACE;
      1: return CHR_TAB;
      2: return CHR_NL;
      3: return CHR_VT;
      4: return CHR_FF;
      default: return CHR_CR;
    endcase
  endfunction

  function automatic void build_text(input int unsigned n);
    int unsigned kind;
    int unsigned len;
    while (text_q.size() < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        // tool token, mostly short so the source often lands in the table
        add_char(any_space());
        add_char($urandom_range(0, 1) ? CHR_UPPER_T : CHR_LOWER_T);
        len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 2) : $urandom_range(3, 11);
        repeat (len) add_char(CHR_ZERO + 8'($urandom_range(0, 9)));
      end else if (kind < 65) begin
        add_char(CHR_SEMI);
        if ($urandom_range(0, 1)) begin
          add_char(CHR_UPPER_T);
          add_char(CHR_ZERO + 8'($urandom_range(0, 9)));
        end
        repeat ($urandom_range(0, 5)) add_char(8'($urandom_range(8'h21, 8'h7e)));
        add_char(CHR_NL);
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 4)) add_char(8'($urandom_range(8'h21, 8'h7e)));
      end else begin
        add_char(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  initial begin
    string directed;
    burst_left = 0;
    hold_req = 1'b0;
    rst_ni <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.in_byte    <= '0;
    in_if.stream_end <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.reg_index <= '0;
    cfg_if.reg_data  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // src1->0, src3->42, src5->127, src6->10, src7 invalid, src8->9, src9->100
    load_table(64'h00_8A_FF_00_AA_00_80_00, 64'h00_00_00_00_00_00_E4_89,
               64'h9F_00_C5_81_00_FF_80_00, 64'h00_FF_7F_80_E3_00_01_9E);
    // line start, mapped/unmapped, comment, overlong, letter alone, flush at end
    directed = "T5 t07;T1\nT1234567890\tT1x\vTx\fT9";
    foreach (directed[i]) add_char(directed[i]);
    for (int unsigned i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();

    for (int unsigned phase = 1; phase <= 4; phase++) begin
      wait_drained();
      case (phase)
        1: load_table('0, '0, '0, '0);
        2: load_table('1, '1, '1, '1);
        default: load_table({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      if (phase == 3) hold_req = 1'b1;
      build_text(PHASE_ITEMS);
      send_text();
    end

    wait_drained();
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* gcode_tool_number_remapper.f */
+incdir+rtl
rtl/gtr_pkg.sv
rtl/gtr_if.sv
rtl/gtr_ctrl.sv
rtl/gtr_dp.sv
rtl/gcode_tool_number_remapper.sv
dv/tool_remap_checker.sv
dv/tb_top.sv
